// ===== rtl/core/s2f_pkg.sv =====
`default_nettype none
package s2f_pkg;

    typedef struct packed {
        logic [31:0] raw_sample;
        logic        last_in;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] float_bits;
        logic        width_error;
        logic        last_out;
    } t_out_beat;

    localparam logic [1:0] WC_8   = 2'd0;
    localparam logic [1:0] WC_16  = 2'd1;
    localparam logic [1:0] WC_32  = 2'd2;
    localparam logic [1:0] WC_BAD = 2'd3;

    localparam logic REG_WIDTH_CODE   = 1'b0;
    localparam logic REG_FLOAT_FORMAT = 1'b1;

    // conversion path selected for one sample
    localparam logic [1:0] PATH_UINT = 2'd0;
    localparam logic [1:0] PATH_HALF = 2'd1;
    localparam logic [1:0] PATH_PASS = 2'd2;
    localparam logic [1:0] PATH_ERR  = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/core/s2f_pipe.sv =====
`default_nettype none
// Three-stage conversion pipe: decode/mask, leading-one count + normalize,
// round + pack. No stall; each stage ends in a register and a beat never waits.
module s2f_pipe
    import s2f_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_in_beat  i_beat,
    input  wire logic [1:0] i_width_code,
    input  wire logic      i_float_format,
    output logic           o_valid,
    output t_out_beat      o_beat
);
    // stage 1
    logic        r_v1, n_v1;
    logic [1:0]  r_path1, n_path1;
    logic [31:0] r_val1, n_val1;
    logic        r_last1;
    // stage 2
    logic        r_v2;
    logic [1:0]  r_path2;
    logic [31:0] r_val2;
    logic [31:0] r_norm2;   // source value (uint, or half mantissa) shifted so leading one sits at bit 31
    logic [4:0]  r_top2;    // bit position of leading one
    logic        r_zero2;
    logic        r_last2;
    // stage 3
    logic        r_v3;
    t_out_beat   r_out3;

    always_comb begin
        n_v1 = i_valid;
        n_val1 = i_beat.raw_sample;
        n_path1 = PATH_UINT;
        case (i_width_code)
            WC_8: begin
                n_val1 = {24'd0, i_beat.raw_sample[7:0]};
            end
            WC_16: begin
                n_val1 = {16'd0, i_beat.raw_sample[15:0]};
                n_path1 = i_float_format ? PATH_HALF : PATH_UINT;
            end
            WC_32: begin
                n_path1 = i_float_format ? PATH_PASS : PATH_UINT;
            end
            default: begin
                n_path1 = PATH_ERR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_path1 <= n_path1;
        r_val1  <= n_val1;
        r_last1 <= i_beat.last_in;
    end

    // leading-one search; for half, search the 10-bit mantissa
    logic [31:0] s_src;
    logic [4:0]  s_top;
    always_comb begin
        s_src = (r_path1 == PATH_HALF) ? {22'd0, r_val1[9:0]} : r_val1;
        s_top = 5'd0;
        for (int k = 0; k < 32; k++) begin
            if (s_src[k]) s_top = 5'(k);
        end
    end

    always_ff @(posedge i_clk) begin
        r_path2 <= r_path1;
        r_val2  <= r_val1;
        r_top2  <= s_top;
        r_zero2 <= (s_src == 32'd0);
        r_norm2 <= s_src << (5'd31 - s_top);
        r_last2 <= r_last1;
    end

    // stage 3: round and pack
    logic [31:0] s_bits;
    logic [24:0] s_mant;
    logic [7:0]  s_exp;
    logic        s_rnd;
    logic [4:0]  s_hex;
    always_comb begin
        s_bits = 32'd0;
        s_exp  = 8'd126 + {3'd0, r_top2};
        // mantissa with hidden bit = norm[31:8]; guard = norm[7], sticky = rest
        s_rnd  = r_norm2[7] && ((|r_norm2[6:0]) || r_norm2[8]);
        s_mant = {1'b0, r_norm2[31:8]} + {24'd0, s_rnd};
        s_hex  = r_val2[14:10];
        case (r_path2)
            PATH_UINT: begin
                if (!r_zero2) s_bits = {1'b0, s_exp, 23'd0} + {7'd0, s_mant};
            end
            PATH_HALF: begin
                if (s_hex == 5'd0) begin
                    if (r_zero2) s_bits = {r_val2[15], 31'd0};
                    else s_bits = {r_val2[15], 8'(r_top2 + 8'd103), r_norm2[30:8]};
                end else if (s_hex == 5'd31) begin
                    s_bits = {r_val2[15], 8'hFF, r_val2[9:0], 13'd0};
                end else begin
                    s_bits = {r_val2[15], 8'({3'd0, s_hex} + 8'd112), r_val2[9:0], 13'd0};
                end
            end
            PATH_PASS: s_bits = r_val2;
            default:   s_bits = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out3.float_bits  <= s_bits;
        r_out3.width_error <= (r_path2 == PATH_ERR);
        r_out3.last_out    <= r_last2;
    end

    assign o_valid = r_v3;
    assign o_beat  = r_out3;
endmodule
`default_nettype wire

// ===== rtl/core/sample_to_float32_converter_unit.sv =====
`default_nettype none
// channel | direction | handshake          | payload
// input   | in        | i_start & !o_busy  | i_in (t_in_beat)
// result  | out       | o_done strobe      | o_out (t_out_beat)
// config  | in        | i_cfg_valid&ready  | i_cfg_index, i_cfg_data
//
// One sample per cycle; each result is registered through every stage.
// The rate is set by the three-stage pipe: mask, leading-one normalize,
// round/pack. o_busy is always low: the receiver cannot stall, so no
// beat ever waits. Synchronous active-low reset empties the pipe and
// restores width_code=16-bit, float_format=integer.
module sample_to_float32_converter_unit
    import s2f_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire t_in_beat  i_in,
    output logic           o_busy,
    output logic           o_done,
    output t_out_beat      o_out,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic      i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    logic [1:0] r_width_code;
    logic       r_float_format;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_code   <= WC_16;
            r_float_format <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_WIDTH_CODE) r_width_code <= i_cfg_data[1:0];
            else r_float_format <= i_cfg_data[0];
        end
    end

    s2f_pipe u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_start && !o_busy),
        .i_beat        (i_in),
        .i_width_code  (r_width_code),
        .i_float_format(r_float_format),
        .o_valid       (o_done),
        .o_beat        (o_out)
    );
endmodule
`default_nettype wire

// ===== rtl/core/s2f_checker.sv =====
`default_nettype none
module s2f_checker
    import s2f_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_start,
    input wire logic      o_busy,
    input wire logic      o_done,
    input wire t_in_beat  i_in,
    input wire t_out_beat o_out
);
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) ##1 i_rst_n ##1 i_rst_n |=> o_done)
        else $error("result missing");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) ##3 o_done |-> o_out.last_out == $past(i_in.last_in, 3))
        else $error("last mark lost");
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.width_error) |-> o_out.float_bits == 32'd0)
        else $error("error beat carries data");
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_start, 3) && $past(i_rst_n, 3) |-> !o_done)
        else $error("spurious result");
endmodule

bind sample_to_float32_converter_unit s2f_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_done(o_done), .i_in(i_in), .o_out(o_out)
);
`default_nettype wire
